// ===== src/lass_pkg.sv =====
`default_nettype none

package lass_pkg;

  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned NUM_TAP   = 4;
  localparam int unsigned CELL_W    = 32;
  localparam int unsigned MW_W      = 20;
  localparam int unsigned AWT_W     = 21;
  localparam int unsigned SUM_W     = 21;
  localparam int unsigned PROD_W    = 30;
  localparam int unsigned NUM_W     = 36;
  localparam int unsigned DEN_W     = 20;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned DEPTH_SH  = 11;

  localparam logic [1:0] LAST_CH  = 2'(NUM_CH - 1);
  localparam logic [1:0] LAST_TAP = 2'(NUM_TAP - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIFT_X  = 3'd0,
    CFG_SHIFT_Y  = 3'd1,
    CFG_DEPTH    = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_LUMA_OFF = 3'd4,
    CFG_CB_OFF   = 3'd5,
    CFG_CR_OFF   = 3'd6,
    CFG_CUTOFF   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_LD_B,
    ST_WR_A,
    ST_WR_B,
    ST_MAC,
    ST_MAC_END,
    ST_ALPHA,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_COLOR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] color;
  } cell_t;

  typedef struct packed {
    logic signed [15:0] alpha_luma;
    logic signed [15:0] color_luma;
    logic signed [15:0] alpha_blue;
    logic signed [15:0] color_blue;
    logic signed [15:0] alpha_red;
    logic signed [15:0] color_red;
    logic               past_right;
    logic               past_bottom;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_alpha_luma;
    logic signed [15:0] out_color_luma;
    logic signed [15:0] out_alpha_blue;
    logic signed [15:0] out_color_blue;
    logic signed [15:0] out_alpha_red;
    logic signed [15:0] out_color_red;
    logic               row_end;
  } out_t;

  typedef struct packed {
    logic       accept;
    logic       rd_a;
    logic       rd_b;
    logic       ld_b;
    logic       wr_a;
    logic       wr_b;
    logic       mac_clr;
    logic       mac_issue;
    logic       alpha_mul;
    logic       div_start;
    logic       color_ld;
    logic       commit;
    logic [1:0] ch;
    logic [1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/logo_alpha_subpixel_shift_core.sv =====
// one item at a time: a new input is taken only once the last result is committed
// per item: three 16-step divisions on the
//   shared divider, after a 4-tap multiply-accumulate per channel
// a finished result waits in the output register while the next item is taken
// reset: asynchronous, active low; config to defaults, row store reads as zero
`default_nettype none

module logo_alpha_subpixel_shift_core #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire lass_pkg::in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lass_pkg::out_t                         out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lass_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lass_pkg::CFG_W-1:0]        cfg_wdata_i
);

  lass_pkg::cmd_t cmd;
  lass_pkg::sts_t sts;

  lass_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lass_dp #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free) else $error("result loaded over a pending one");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second item taken");

  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.rd_a, cmd.rd_b, cmd.wr_a, cmd.wr_b})) else $error("row store conflict");

endmodule

`default_nettype wire

// ===== src/lass_ram.sv =====
`default_nettype none

module lass_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 257
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/lass_div.sv =====
`default_nettype none

module lass_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [lass_pkg::NUM_W-1:0]    num_i,
  input  wire logic        [lass_pkg::DEN_W-1:0]    den_i,
  output logic                                      done_o,
  output logic signed      [lass_pkg::QUO_W:0]      quo_o
);

  localparam int unsigned NW    = lass_pkg::NUM_W;
  localparam int unsigned DW    = lass_pkg::DEN_W;
  localparam int unsigned QW    = lass_pkg::QUO_W;
  localparam int unsigned REM_W = DW + 1;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic              busy_q, done_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [REM_W-1:0]  rem_q;
  logic [QW-1:0]     quo_q;
  logic [DW-1:0]     den_q;
  logic [NW-1:0]     mag;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    mag   = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    trial = {rem_q[DW-1:0], quo_q[QW-1]};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      den_q <= den_i;
      rem_q <= REM_W'(mag >> QW);
      quo_q <= mag[QW-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? trial - {1'b0, den_q} : trial;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

`default_nettype wire

// ===== src/lass_ctrl.sv =====
`default_nettype none

module lass_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lass_pkg::sts_t  sts_i,
  output lass_pkg::cmd_t       cmd_o
);

  lass_pkg::state_e state_q, state_d;
  logic [1:0] ch_q, tap_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lass_pkg::ST_IDLE:     if (in_valid_i) state_d = lass_pkg::ST_RD_A;
      lass_pkg::ST_RD_A:     state_d = lass_pkg::ST_RD_B;
      lass_pkg::ST_RD_B:     state_d = lass_pkg::ST_LD_B;
      lass_pkg::ST_LD_B:     state_d = lass_pkg::ST_WR_A;
      lass_pkg::ST_WR_A:     state_d = lass_pkg::ST_WR_B;
      lass_pkg::ST_WR_B:     state_d = lass_pkg::ST_MAC;
      lass_pkg::ST_MAC: begin
        if (tap_q == lass_pkg::LAST_TAP) state_d = lass_pkg::ST_MAC_END;
      end
      lass_pkg::ST_MAC_END:  state_d = lass_pkg::ST_ALPHA;
      lass_pkg::ST_ALPHA:    state_d = lass_pkg::ST_DIV_GO;
      lass_pkg::ST_DIV_GO:   state_d = lass_pkg::ST_DIV_WAIT;
      lass_pkg::ST_DIV_WAIT: if (sts_i.div_done) state_d = lass_pkg::ST_COLOR;
      lass_pkg::ST_COLOR: begin
        state_d = (ch_q == lass_pkg::LAST_CH) ? lass_pkg::ST_OUT : lass_pkg::ST_MAC;
      end
      lass_pkg::ST_OUT:      if (sts_i.out_free) state_d = lass_pkg::ST_IDLE;
      default:               state_d = lass_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.ch        = ch_q;
    cmd_o.tap       = tap_q;
    in_ready_o      = 1'b0;
    case (state_q)
      lass_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      lass_pkg::ST_RD_A:   cmd_o.rd_a = 1'b1;
      lass_pkg::ST_RD_B:   cmd_o.rd_b = 1'b1;
      lass_pkg::ST_LD_B:   cmd_o.ld_b = 1'b1;
      lass_pkg::ST_WR_A:   cmd_o.wr_a = 1'b1;
      lass_pkg::ST_WR_B:   cmd_o.wr_b = 1'b1;
      lass_pkg::ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.mac_clr   = (tap_q == 2'd0);
      end
      lass_pkg::ST_ALPHA:  cmd_o.alpha_mul = 1'b1;
      lass_pkg::ST_DIV_GO: cmd_o.div_start = 1'b1;
      lass_pkg::ST_COLOR:  cmd_o.color_ld  = 1'b1;
      lass_pkg::ST_OUT:    cmd_o.commit    = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lass_pkg::ST_IDLE;
      ch_q    <= '0;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == lass_pkg::ST_MAC) begin
        tap_q <= tap_q + 2'd1;
      end
      if (state_q == lass_pkg::ST_COLOR) begin
        ch_q <= (ch_q == lass_pkg::LAST_CH) ? 2'd0 : ch_q + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/lass_dp.sv =====
`default_nettype none

module lass_dp #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lass_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lass_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  wire lass_pkg::in_t                     in_data_i,
  input  wire lass_pkg::cmd_t                    cmd_i,
  output lass_pkg::sts_t                         sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lass_pkg::out_t                         out_data_o
);

  localparam int unsigned DEPTH = MAX_WIDTH + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = lass_pkg::CELL_W;
  localparam int unsigned RW    = CW * lass_pkg::NUM_CH;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7fff;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // configuration
  logic [1:0]        sx_q, sy_q;
  logic [7:0]        depth_q;
  logic [8:0]        width_q;
  logic signed [8:0] off_q [lass_pkg::NUM_CH];
  logic [14:0]       cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q     <= '0;
      sy_q     <= '0;
      depth_q  <= 8'd128;
      width_q  <= 9'd1;
      off_q    <= '{default: '0};
      cutoff_q <= '0;
    end else if (cfg_we_i) begin
      case (lass_pkg::cfg_idx_e'(cfg_idx_i))
        lass_pkg::CFG_SHIFT_X:  sx_q     <= cfg_wdata_i[1:0];
        lass_pkg::CFG_SHIFT_Y:  sy_q     <= cfg_wdata_i[1:0];
        lass_pkg::CFG_DEPTH:    depth_q  <= cfg_wdata_i[7:0];
        lass_pkg::CFG_WIDTH:    width_q  <= cfg_wdata_i[8:0];
        lass_pkg::CFG_LUMA_OFF: off_q[0] <= cfg_wdata_i[8:0];
        lass_pkg::CFG_CB_OFF:   off_q[1] <= cfg_wdata_i[8:0];
        lass_pkg::CFG_CR_OFF:   off_q[2] <= cfg_wdata_i[8:0];
        lass_pkg::CFG_CUTOFF:   cutoff_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // position and neighbor state
  logic [AW-1:0]         col_q, eff_w, col;
  logic                  top_q;
  lass_pkg::cell_t       left_q [lass_pkg::NUM_CH];
  logic                  rowend, bottom;
  logic signed [15:0]    in_a [lass_pkg::NUM_CH];
  logic signed [15:0]    in_c [lass_pkg::NUM_CH];

  always_comb begin
    if (width_q == '0) begin
      eff_w = AW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = AW'(MAX_WIDTH);
    end else begin
      eff_w = AW'(width_q);
    end
    col    = (col_q > eff_w) ? eff_w : col_q;
    bottom = in_data_i.past_bottom;
    rowend = in_data_i.past_right || (col >= eff_w);
    in_a[0] = in_data_i.alpha_luma;
    in_c[0] = in_data_i.color_luma;
    in_a[1] = in_data_i.alpha_blue;
    in_c[1] = in_data_i.color_blue;
    in_a[2] = in_data_i.alpha_red;
    in_c[2] = in_data_i.color_red;
  end

  // item registers and 2x2 window
  logic [AW-1:0]   col_r_q;
  logic            rowend_q, bottom_q, corner_q;
  logic [1:0]      pick_q;
  lass_pkg::cell_t win_q [lass_pkg::NUM_CH][lass_pkg::NUM_TAP];

  // row store
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [RW-1:0]   wdata, rdata;
  logic [AW:0]     fill_q;
  logic            rvld_q;

  always_comb begin
    raddr = (cmd_i.rd_a && col_r_q != '0) ? col_r_q - AW'(1) : col_r_q;
    waddr = cmd_i.wr_a ? col_r_q - AW'(1) : col_r_q;
    we    = (cmd_i.wr_a && col_r_q != '0) || (cmd_i.wr_b && rowend_q);
    for (int c = 0; c < lass_pkg::NUM_CH; c++) begin
      wdata[c*CW +: CW] = cmd_i.wr_a ? win_q[c][2] : win_q[c][3];
    end
  end

  lass_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // written entries always form a prefix from address 0, so a fill count
  // tells never-written entries apart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we && {1'b0, waddr} >= fill_q) begin
        fill_q <= {1'b0, waddr} + (AW+1)'(1);
      end
      rvld_q <= {1'b0, raddr} < fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_r_q  <= col;
      rowend_q <= rowend;
      bottom_q <= bottom;
      corner_q <= (top_q || bottom) && (col == '0 || rowend);
      pick_q   <= {~bottom, ~rowend};
      for (int c = 0; c < lass_pkg::NUM_CH; c++) begin
        win_q[c][0] <= '0;
        win_q[c][1] <= '0;
        win_q[c][2] <= (col != '0) ? left_q[c] : '0;
        win_q[c][3] <= {((rowend || bottom) ? 16'sd0 : in_a[c]), in_c[c]};
      end
    end
    if (cmd_i.rd_b) begin
      for (int c = 0; c < lass_pkg::NUM_CH; c++) begin
        win_q[c][0] <= (!top_q && col_r_q != '0 && rvld_q) ? rdata[c*CW +: CW] : '0;
      end
    end
    if (cmd_i.ld_b) begin
      for (int c = 0; c < lass_pkg::NUM_CH; c++) begin
        win_q[c][1] <= (!top_q && rvld_q) ? rdata[c*CW +: CW] : '0;
      end
    end
  end

  // weighted sums, one window tap per cycle
  lass_pkg::cell_t                     sel;
  logic [2:0]                          wx, wy;
  logic [5:0]                          wprod;
  logic [4:0]                          wt;
  logic [16:0]                         mag;
  logic [21:0]                         mw_full;
  logic signed [lass_pkg::AWT_W-1:0]   a_ext, w_ext, aw_d;
  logic [lass_pkg::MW_W-1:0]           mw_q;
  logic signed [lass_pkg::AWT_W-1:0]   aw_q;
  logic signed [15:0]                  csel_q;
  logic                                acc_v_q;
  logic signed [lass_pkg::NUM_W-1:0]   c_ext, m_ext, cm;
  logic signed [lass_pkg::NUM_W-1:0]   num_q;
  logic [lass_pkg::DEN_W-1:0]          den_q;
  logic signed [lass_pkg::SUM_W-1:0]   s_q;
  logic signed [lass_pkg::PROD_W-1:0]  ad_q, ad_adj;
  logic signed [18:0]                  a_div;

  always_comb begin
    sel     = win_q[cmd_i.ch][cmd_i.tap];
    wx      = cmd_i.tap[0] ? 3'd4 - {1'b0, sx_q} : {1'b0, sx_q};
    wy      = cmd_i.tap[1] ? 3'd4 - {1'b0, sy_q} : {1'b0, sy_q};
    wprod   = {3'b0, wx} * {3'b0, wy};
    wt      = wprod[4:0];
    mag     = sel.alpha[15] ? 17'd0 - {sel.alpha[15], sel.alpha} : {1'b0, sel.alpha};
    mw_full = {5'b0, mag} * {17'b0, wt};
    a_ext   = lass_pkg::AWT_W'(sel.alpha);
    w_ext   = $signed({16'b0, wt});
    aw_d    = a_ext * w_ext;
    c_ext   = lass_pkg::NUM_W'(csel_q);
    m_ext   = $signed({16'b0, mw_q});
    cm      = c_ext * m_ext;
    ad_adj  = ad_q + (ad_q[lass_pkg::PROD_W-1] ? 30'sd2047 : 30'sd0);
    a_div   = 19'(ad_adj >>> lass_pkg::DEPTH_SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q <= 1'b0;
    end else begin
      acc_v_q <= cmd_i.mac_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_issue) begin
      mw_q   <= mw_full[lass_pkg::MW_W-1:0];
      aw_q   <= aw_d;
      csel_q <= sel.color;
    end
    if (cmd_i.mac_clr) begin
      num_q <= '0;
      den_q <= '0;
      s_q   <= '0;
    end else if (acc_v_q) begin
      num_q <= num_q + cm;
      den_q <= den_q + mw_q;
      s_q   <= s_q + aw_q;
    end
    if (cmd_i.alpha_mul) begin
      ad_q <= lass_pkg::PROD_W'(s_q) * $signed({22'b0, depth_q});
    end
  end

  // shared divider
  logic                          div_done;
  logic signed [lass_pkg::QUO_W:0] quo;

  lass_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // per-channel results
  logic signed [15:0] oa_q [lass_pkg::NUM_CH];
  logic signed [15:0] oc_q [lass_pkg::NUM_CH];
  logic signed [16:0] c_val;
  logic signed [17:0] c_sum;
  lass_pkg::cell_t    pick_cell;

  always_comb begin
    pick_cell = win_q[cmd_i.ch][pick_q];
    if (corner_q) begin
      c_val = 17'(pick_cell.color);
    end else if (oa_q[cmd_i.ch] != '0 && den_q != '0) begin
      c_val = quo;
    end else begin
      c_val = '0;
    end
    c_sum = 18'(c_val) + 18'($signed({off_q[cmd_i.ch], 4'b0}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      oa_q[cmd_i.ch] <= sat16(a_div);
    end
    if (cmd_i.color_ld) begin
      oc_q[cmd_i.ch] <= sat16(19'(c_sum));
    end
  end

  // cutoff and output register
  logic           cut;
  logic           out_valid_q;
  lass_pkg::out_t out_q;

  always_comb begin
    cut = cutoff_q != '0;
    for (int c = 0; c < lass_pkg::NUM_CH; c++) begin
      cut = cut && (17'(oa_q[c]) < $signed({2'b0, cutoff_q}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      col_q       <= '0;
      top_q       <= 1'b1;
      left_q      <= '{default: '0};
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (rowend_q) begin
          col_q <= '0;
          top_q <= bottom_q;
        end else begin
          col_q <= col_r_q + AW'(1);
        end
        for (int c = 0; c < lass_pkg::NUM_CH; c++) begin
          left_q[c] <= win_q[c][3];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.out_alpha_luma <= cut ? 16'sd0 : oa_q[0];
      out_q.out_alpha_blue <= cut ? 16'sd0 : oa_q[1];
      out_q.out_alpha_red  <= cut ? 16'sd0 : oa_q[2];
      out_q.out_color_luma <= oc_q[0];
      out_q.out_color_blue <= oc_q[1];
      out_q.out_color_red  <= oc_q[2];
      out_q.row_end        <= rowend_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire
